[sv/alsb_pkg.sv]
// shared types and constants for the adaptive replacement engine
package alsb_pkg;
    localparam logic [2:0] MODE_LRU   = 3'b001;
    localparam logic [2:0] MODE_SRRIP = 3'b010;
    localparam logic [2:0] MODE_BIP   = 3'b100;

    localparam logic [2:0] CFG_REUSE    = 3'd0;
    localparam logic [2:0] CFG_MODERATE = 3'd1;
    localparam logic [2:0] CFG_STRIDE   = 3'd2;
    localparam logic [2:0] CFG_RANDOM   = 3'd3;
    localparam logic [2:0] CFG_ODDS     = 3'd4;
    localparam logic [2:0] CFG_SEED     = 3'd5;

    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EXEC
    } t_state;

    // configuration values seen by the datapath
    typedef struct packed {
        logic [5:0]  reuse_hits;
        logic [5:0]  moderate_hits;
        logic [15:0] stride_limit;
        logic [7:0]  random_threshold;
        logic [3:0]  odds_log2;
    } t_cfg;
endpackage

[sv/alsb_cfg_regs.sv]
// configuration register file
module alsb_cfg_regs (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_valid,
    input  logic [2:0]      i_cfg_index,
    input  logic [15:0]     i_cfg_data,
    output alsb_pkg::t_cfg  o_cfg,
    output logic            o_seed_load,
    output logic [15:0]     o_seed
);
    alsb_pkg::t_cfg r_cfg;
    logic           r_seed_load;
    logic [15:0]    r_seed;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reuse_hits       <= 6'd13;
            r_cfg.moderate_hits    <= 6'd7;
            r_cfg.stride_limit     <= 16'd4096;
            r_cfg.random_threshold <= 8'd8;
            r_cfg.odds_log2        <= 4'd5;
            r_seed                 <= 16'd44257;
            r_seed_load            <= 1'b1;
        end else begin
            r_seed_load <= 1'b0;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    alsb_pkg::CFG_REUSE:    r_cfg.reuse_hits <= i_cfg_data[5:0];
                    alsb_pkg::CFG_MODERATE: r_cfg.moderate_hits <= i_cfg_data[5:0];
                    alsb_pkg::CFG_STRIDE:   r_cfg.stride_limit <= i_cfg_data;
                    alsb_pkg::CFG_RANDOM:   r_cfg.random_threshold <= i_cfg_data[7:0];
                    alsb_pkg::CFG_ODDS:     r_cfg.odds_log2 <= i_cfg_data[3:0];
                    alsb_pkg::CFG_SEED: begin
                        r_seed      <= (i_cfg_data == 16'd0) ? 16'd1 : i_cfg_data;
                        r_seed_load <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_cfg       = r_cfg;
    assign o_seed_load = r_seed_load;
    assign o_seed      = r_seed;
endmodule

[sv/alsb_core.sv]
// set metadata memory with read-modify-write sequencer
module alsb_core #(
    parameter int SETS      = 2048,
    parameter int WAYS      = 16,
    parameter int WINDOW    = 32,
    parameter int ADDR_BITS = 48
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  alsb_pkg::t_cfg       i_cfg,
    input  logic                 i_seed_load,
    input  logic [15:0]          i_seed,
    input  logic                 i_start,
    input  logic                 i_func,
    input  logic [10:0]          i_set_index,
    input  logic [3:0]           i_way_index,
    input  logic                 i_was_hit,
    input  logic [47:0]          i_phys_addr,
    input  logic [15:0]          i_valid_mask,
    output logic                 o_busy,
    output logic                 o_done,
    output logic [3:0]           o_victim_way,
    output logic                 o_reply_kind
);
    localparam int SW = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WW = $clog2(WAYS);
    localparam int RW = $clog2(WAYS);
    localparam int PW = $clog2(WINDOW);
    localparam int CW = $clog2(WINDOW + 1);
    localparam int MW = WINDOW + PW + ADDR_BITS + 8 + 3 + WAYS * (RW + 2);
    localparam logic [RW-1:0] REC_MAX = RW'(WAYS - 1);

    typedef struct packed {
        logic [WINDOW-1:0]        win;
        logic [PW-1:0]            ptr;
        logic [ADDR_BITS-1:0]     prev;
        logic [7:0]               score;
        logic [2:0]               modes;
        logic [WAYS-1:0][RW-1:0]  rec;
        logic [WAYS-1:0][1:0]     rrpv;
    } t_entry;

    // set memory
    logic [MW-1:0] r_mem [SETS];
    t_entry        r_rd;
    logic          r_we;
    logic [SW-1:0] r_waddr;
    t_entry        r_wdata;

    alsb_pkg::t_state r_state, n_state;
    logic [SW-1:0]    r_clr, r_set;
    logic             r_func, r_hit;
    logic [3:0]       r_way;
    logic [ADDR_BITS-1:0] r_addr;
    logic [15:0]      r_vmask;
    logic [15:0]      r_lfsr;
    logic             r_done;
    logic [3:0]       r_victim;
    logic             r_kind;

    t_entry           n_entry, clr_entry;
    logic [3:0]       n_victim;
    logic             n_lfsr_step;
    logic [15:0]      n_lfsr;
    logic [SW-1:0]    set_sel;

    // set index reduced by the set count, conditional subtract of shifted set counts
    always_comb begin
        logic [11:0] rem;
        rem = {1'b0, i_set_index};
        for (int k = 10; k >= 0; k--)
            if ((64'(SETS) << k) <= 64'd2047 && 64'(rem) >= (64'(SETS) << k))
                rem = rem - 12'(64'(SETS) << k);
        set_sel = SW'(rem);
    end

    always_comb begin
        clr_entry = '0;
        for (int w = 0; w < WAYS; w++) clr_entry.rrpv[w] = 2'd3;
    end

    always_ff @(posedge i_clk) begin
        if (r_we) r_mem[r_waddr] <= r_wdata;
        r_rd <= r_mem[r_set];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            alsb_pkg::ST_CLEAR: if (r_clr == SW'(SETS - 1)) n_state = alsb_pkg::ST_IDLE;
            alsb_pkg::ST_IDLE:  if (i_start) n_state = alsb_pkg::ST_READ;
            alsb_pkg::ST_READ:  n_state = alsb_pkg::ST_EXEC;
            alsb_pkg::ST_EXEC:  n_state = alsb_pkg::ST_IDLE;
            default:            n_state = alsb_pkg::ST_IDLE;
        endcase
    end

    assign o_busy = (r_state != alsb_pkg::ST_IDLE);

    // modify step
    always_comb begin
        logic [CW-1:0]        hits;
        logic [2:0]           modes;
        logic                 bip, mru, found;
        logic [ADDR_BITS-1:0] d;
        logic [1:0]           maxr, v;
        logic [RW-1:0]        old, top;
        logic [15:0]          mask;
        n_entry     = r_rd;
        n_victim    = '0;
        n_lfsr_step = 1'b0;
        n_lfsr      = {1'b0, r_lfsr[15:1]} ^ (r_lfsr[0] ? alsb_pkg::LFSR_TAPS : 16'd0);
        hits = '0; modes = '0; bip = 1'b0; mru = 1'b0; found = 1'b0;
        d = '0; maxr = '0; v = '0; old = '0; top = '0; mask = '0;
        if (!r_func) begin
            if ((r_rd.modes & (alsb_pkg::MODE_BIP | alsb_pkg::MODE_LRU)) != 3'd0) begin
                for (int w = 0; w < WAYS; w++)
                    if (!found && !(w < 16 && r_vmask[w])) begin
                        found = 1'b1; n_victim = 4'(w);
                    end
                if (!found)
                    for (int w = 0; w < WAYS; w++)
                        if (r_rd.rec[w] >= top) begin
                            top = r_rd.rec[w]; n_victim = 4'(w);
                        end
            end else begin
                for (int w = 0; w < WAYS; w++) begin
                    if (!found && (!(w < 16 && r_vmask[w]) || r_rd.rrpv[w] == 2'd3)) begin
                        found = 1'b1; n_victim = 4'(w);
                    end
                    if (r_rd.rrpv[w] > maxr) maxr = r_rd.rrpv[w];
                end
                if (!found) begin
                    for (int w = 0; w < WAYS; w++)
                        n_entry.rrpv[w] = r_rd.rrpv[w] + (2'd3 - maxr);
                    for (int w = 0; w < WAYS; w++)
                        if (!found && n_entry.rrpv[w] == 2'd3) begin
                            found = 1'b1; n_victim = 4'(w);
                        end
                end
            end
        end else begin
            n_entry.win[r_rd.ptr] = r_hit;
            n_entry.ptr = (32'(r_rd.ptr) == WINDOW - 1) ? '0 : r_rd.ptr + 1'b1;
            for (int i = 0; i < WINDOW; i++) hits = hits + CW'(n_entry.win[i]);
            if (32'(hits) >= 32'(i_cfg.reuse_hits)) modes = alsb_pkg::MODE_LRU;
            else if (32'(hits) >= 32'(i_cfg.moderate_hits)) modes = alsb_pkg::MODE_SRRIP;
            if (r_rd.prev != '0) begin
                d = (r_addr >= r_rd.prev) ? r_addr - r_rd.prev : r_rd.prev - r_addr;
                if (d == '0 || d > ADDR_BITS'(i_cfg.stride_limit)) begin
                    if (r_rd.score != 8'hFF) n_entry.score = r_rd.score + 8'd1;
                end else if (r_rd.score != 8'd0) n_entry.score = r_rd.score - 8'd1;
                bip = n_entry.score >= i_cfg.random_threshold;
            end
            n_entry.prev = r_addr;
            if (bip) modes = modes | alsb_pkg::MODE_BIP;
            n_entry.modes = modes;
            if (32'(r_way) < WAYS) begin
                if (r_hit) begin
                    old = r_rd.rec[r_way[WW-1:0]];
                    for (int w = 0; w < WAYS; w++)
                        if (r_rd.rec[w] < old && r_rd.rec[w] < REC_MAX)
                            n_entry.rec[w] = r_rd.rec[w] + 1'b1;
                    n_entry.rec[r_way[WW-1:0]]  = '0;
                    n_entry.rrpv[r_way[WW-1:0]] = 2'd0;
                end else if (bip) begin
                    n_lfsr_step = 1'b1;
                    mask = 16'((32'd1 << i_cfg.odds_log2) - 32'd1);
                    mru  = (n_lfsr & mask) == 16'd0;
                    for (int w = 0; w < WAYS; w++)
                        if (r_rd.rec[w] < REC_MAX) n_entry.rec[w] = r_rd.rec[w] + 1'b1;
                    n_entry.rec[r_way[WW-1:0]]  = mru ? '0 : REC_MAX;
                    n_entry.rrpv[r_way[WW-1:0]] = mru ? 2'd0 : 2'd3;
                end else if (modes[0]) begin
                    for (int w = 0; w < WAYS; w++)
                        if (r_rd.rec[w] < REC_MAX) n_entry.rec[w] = r_rd.rec[w] + 1'b1;
                    n_entry.rec[r_way[WW-1:0]]  = '0;
                    n_entry.rrpv[r_way[WW-1:0]] = 2'd0;
                end else begin
                    v = modes[1] ? 2'd2 : 2'd3;
                    n_entry.rrpv[r_way[WW-1:0]] = v;
                    n_entry.rec[r_way[WW-1:0]]  = REC_MAX;
                end
            end
        end
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= alsb_pkg::ST_CLEAR;
            r_clr   <= '0;
            r_we    <= 1'b0;
            r_done  <= 1'b0;
            r_lfsr  <= 16'd44257;
        end else begin
            r_state <= n_state;
            r_we    <= 1'b0;
            r_done  <= 1'b0;
            if (i_seed_load) r_lfsr <= i_seed;
            else if (r_state == alsb_pkg::ST_EXEC && n_lfsr_step) r_lfsr <= n_lfsr;
            if (r_state == alsb_pkg::ST_CLEAR) begin
                r_we    <= 1'b1;
                r_waddr <= r_clr;
                r_wdata <= clr_entry;
                r_clr   <= r_clr + 1'b1;
            end
            if (r_state == alsb_pkg::ST_IDLE && i_start) begin
                r_set   <= set_sel;
                r_func  <= i_func;
                r_hit   <= i_was_hit;
                r_way   <= i_way_index;
                r_addr  <= ADDR_BITS'(i_phys_addr);
                r_vmask <= i_valid_mask;
            end
            if (r_state == alsb_pkg::ST_EXEC) begin
                r_we     <= 1'b1;
                r_waddr  <= r_set;
                r_wdata  <= n_entry;
                r_done   <= 1'b1;
                r_victim <= n_victim;
                r_kind   <= r_func;
            end
        end
    end

    assign o_done       = r_done;
    assign o_victim_way = r_victim;
    assign o_reply_kind = r_kind;
endmodule

[sv/adaptive_lru_srrip_bip_replacement.sv]
// top level of the adaptive replacement engine
// an accepted request passes the read and exec states, then the result strobes
// busy holds off a new request while one set is read and modified
// the write back lands the cycle the next request is accepted, read sees it next cycle
// reset: a clearing pass writes every set in the set memory in turn, busy stays high
// results are shown for one cycle only since the receiver cannot stall
module adaptive_lru_srrip_bip_replacement #(
    parameter int SETS      = 2048,
    parameter int WAYS      = 16,
    parameter int WINDOW    = 32,
    parameter int ADDR_BITS = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_func,
    input  logic [10:0] i_set_index,
    input  logic [3:0]  i_way_index,
    input  logic        i_was_hit,
    input  logic [47:0] i_phys_addr,
    input  logic [15:0] i_valid_mask,
    output logic        o_done,
    output logic [3:0]  o_victim_way,
    output logic        o_reply_kind,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    alsb_pkg::t_cfg cfg;
    logic           seed_load;
    logic [15:0]    seed;

    assign o_cfg_ready = 1'b1;

    alsb_cfg_regs u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_valid(i_cfg_valid),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_cfg(cfg), .o_seed_load(seed_load), .o_seed(seed)
    );

    alsb_core #(.SETS(SETS), .WAYS(WAYS), .WINDOW(WINDOW), .ADDR_BITS(ADDR_BITS)) u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(cfg), .i_seed_load(seed_load),
        .i_seed(seed), .i_start(start), .i_func(i_func), .i_set_index(i_set_index),
        .i_way_index(i_way_index), .i_was_hit(i_was_hit), .i_phys_addr(i_phys_addr),
        .i_valid_mask(i_valid_mask), .o_busy(busy), .o_done(o_done),
        .o_victim_way(o_victim_way), .o_reply_kind(o_reply_kind)
    );
endmodule

[sv/alsb_checker.sv]
// port level checks for the replacement engine
module alsb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_done,
    input logic       o_reply_kind
);
    // an accepted request makes the block busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("not busy after request");
    // an accepted request is followed by a result strobe once it passes the read and exec states
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_done) else $error("missing result");
    // result strobe is a single cycle
    a_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result held");
    // no result while a request could be accepted the cycle before without one
    a_nostray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy)) else $error("stray result");
    // reply kind is driven whenever a result strobes
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !$isunknown(o_reply_kind)) else $error("reply kind unknown");
endmodule

bind adaptive_lru_srrip_bip_replacement alsb_checker u_alsb_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_done(o_done), .o_reply_kind(o_reply_kind)
);

[tb/replacement_checker.sv]
// checker for the adaptive replacement engine: predicts victim answers and update acks
module replacement_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        i_func,
    input  logic [10:0] i_set_index,
    input  logic [3:0]  i_way_index,
    input  logic        i_was_hit,
    input  logic [47:0] i_phys_addr,
    input  logic [15:0] i_valid_mask,
    input  logic        o_done,
    input  logic [3:0]  o_victim_way,
    input  logic        o_reply_kind,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSETS = 2048;
    localparam int NWAYS = 16;

    typedef struct packed {
        logic [3:0] way;
        logic       kind;
    } t_reply;

    t_reply          replies_due[$];
    alsb_pkg::t_cfg  cfg;
    logic [15:0] lfsr;
    logic [31:0] window_bits [NSETS];
    logic [4:0]  window_ptr [NSETS];
    logic [47:0] prev_addr [NSETS];
    logic [7:0]  score [NSETS];
    logic [2:0]  modes [NSETS];
    logic [3:0]  recency [NSETS][NWAYS];
    logic [1:0]  rrpv [NSETS][NWAYS];

    assign o_pending = replies_due.size();

    // oldest-line way of a set, last of equal maxima
    function automatic logic [3:0] oldest_way(int s);
        logic [3:0] best;
        logic [3:0] top;
        best = 0;
        top = 0;
        for (int w = 0; w < NWAYS; w++) begin
            if (recency[s][w] >= top) begin
                top = recency[s][w];
                best = 4'(w);
            end
        end
        return best;
    endfunction

    // choose eviction way, aging rrpv when nothing is distant
    function automatic logic [3:0] pick_victim(int s, logic [15:0] vmask);
        logic [1:0] maxr;
        int v;
        maxr = 0;
        if ((modes[s] & (alsb_pkg::MODE_BIP | alsb_pkg::MODE_LRU)) != 0) begin
            for (int w = 0; w < NWAYS; w++)
                if (!vmask[w]) return 4'(w);
            return oldest_way(s);
        end
        for (int w = 0; w < NWAYS; w++) begin
            if (!vmask[w] || rrpv[s][w] == 2'd3) return 4'(w);
            if (rrpv[s][w] > maxr) maxr = rrpv[s][w];
        end
        for (int w = 0; w < NWAYS; w++) begin
            v = rrpv[s][w] + (3 - maxr);
            rrpv[s][w] = (v > 3) ? 2'd3 : v[1:0];
        end
        for (int w = 0; w < NWAYS; w++)
            if (rrpv[s][w] == 2'd3) return 4'(w);
        return 0;
    endfunction

    // access update: window, stride score, modes, then per-way insertion
    task automatic apply_access(int s, int way, logic hit, logic [47:0] addr);
        int hits;
        logic [2:0] m;
        logic bip;
        logic [47:0] d;
        logic [3:0] old;
        logic lsb;
        logic mru;
        logic [15:0] mask;
        m = 0;
        bip = 0;
        window_bits[s][window_ptr[s]] = hit;
        window_ptr[s] = window_ptr[s] + 5'd1;
        hits = $countones(window_bits[s]);
        if (hits >= cfg.reuse_hits) m |= alsb_pkg::MODE_LRU;
        else if (hits >= cfg.moderate_hits) m |= alsb_pkg::MODE_SRRIP;
        if (prev_addr[s] != 0) begin
            d = (addr >= prev_addr[s]) ? addr - prev_addr[s] : prev_addr[s] - addr;
            if (d == 0 || d > {32'd0, cfg.stride_limit}) begin
                if (score[s] < 8'd255) score[s]++;
            end else if (score[s] > 0) begin
                score[s]--;
            end
            bip = score[s] >= cfg.random_threshold;
        end
        prev_addr[s] = addr;
        if (bip) m |= alsb_pkg::MODE_BIP;
        modes[s] = m;
        if (hit) begin
            old = recency[s][way];
            for (int w = 0; w < NWAYS; w++)
                if (recency[s][w] < old && recency[s][w] < NWAYS - 1) recency[s][w]++;
            recency[s][way] = 0;
            rrpv[s][way] = 0;
        end else if (bip) begin
            lsb = lfsr[0];
            lfsr = lfsr >> 1;
            if (lsb) lfsr ^= alsb_pkg::LFSR_TAPS;
            mask = (16'd1 << cfg.odds_log2) - 16'd1;
            mru = (lfsr & mask) == 0;
            for (int w = 0; w < NWAYS; w++)
                if (recency[s][w] < NWAYS - 1) recency[s][w]++;
            recency[s][way] = mru ? 4'd0 : 4'(NWAYS - 1);
            rrpv[s][way] = mru ? 2'd0 : 2'd3;
        end else if ((m & alsb_pkg::MODE_LRU) != 0) begin
            for (int w = 0; w < NWAYS; w++)
                if (recency[s][w] < NWAYS - 1) recency[s][w]++;
            recency[s][way] = 0;
            rrpv[s][way] = 0;
        end else if ((m & alsb_pkg::MODE_SRRIP) != 0) begin
            rrpv[s][way] = 2;
            recency[s][way] = 4'(NWAYS - 1);
        end else begin
            rrpv[s][way] = 3;
            recency[s][way] = 4'(NWAYS - 1);
        end
    endtask

    // watch request, config and result channels
    always @(posedge i_clk) begin
        t_reply got;
        t_reply want;
        if (!i_rst_n) begin
            cfg = '{6'd13, 6'd7, 16'd4096, 8'd8, 4'd5};
            lfsr = 16'd44257;
            o_errors <= 0;
            replies_due.delete();
            for (int s = 0; s < NSETS; s++) begin
                window_bits[s] = 0;
                window_ptr[s] = 0;
                prev_addr[s] = 0;
                score[s] = 0;
                modes[s] = 0;
                for (int w = 0; w < NWAYS; w++) begin
                    recency[s][w] = 0;
                    rrpv[s][w] = 3;
                end
            end
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    alsb_pkg::CFG_REUSE:    cfg.reuse_hits = i_cfg_data[5:0];
                    alsb_pkg::CFG_MODERATE: cfg.moderate_hits = i_cfg_data[5:0];
                    alsb_pkg::CFG_STRIDE:   cfg.stride_limit = i_cfg_data;
                    alsb_pkg::CFG_RANDOM:   cfg.random_threshold = i_cfg_data[7:0];
                    alsb_pkg::CFG_ODDS:     cfg.odds_log2 = i_cfg_data[3:0];
                    alsb_pkg::CFG_SEED:     lfsr = (i_cfg_data == 0) ? 16'd1 : i_cfg_data;
                    default: ;
                endcase
            end
            if (o_done) begin
                got = '{o_victim_way, o_reply_kind};
                if (replies_due.size() == 0) begin
                    $display("%0t: unexpected result way=%0d kind=%0d", $time,
                             got.way, got.kind);
                    o_errors <= o_errors + 1;
                end else begin
                    want = replies_due.pop_front();
                    if (got.way !== want.way) begin
                        $display("%0t: victim_way expected %0d actual %0d", $time,
                                 want.way, got.way);
                        o_errors <= o_errors + 1;
                    end
                    if (got.kind !== want.kind) begin
                        $display("%0t: reply_kind expected %0d actual %0d", $time,
                                 want.kind, got.kind);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (start && !busy) begin
                if (!i_func) begin
                    replies_due.push_back('{pick_victim(i_set_index, i_valid_mask), 1'b0});
                end else begin
                    apply_access(i_set_index, i_way_index, i_was_hit, i_phys_addr);
                    replies_due.push_back('{4'd0, 1'b1});
                end
            end
        end
    end
endmodule

[tb/tb_top.sv]
// stimulus and verdict for the adaptive replacement engine testbench
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_func;
    logic [10:0] i_set_index;
    logic [3:0]  i_way_index;
    logic        i_was_hit;
    logic [47:0] i_phys_addr;
    logic [15:0] i_valid_mask;
    logic        o_done;
    logic [3:0]  o_victim_way;
    logic        o_reply_kind;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    int          errors;
    int          pending;

    adaptive_lru_srrip_bip_replacement uut (.*);

    replacement_checker chk (
        .i_clk, .i_rst_n, .start, .busy, .i_func, .i_set_index, .i_way_index,
        .i_was_hit, .i_phys_addr, .i_valid_mask, .o_done, .o_victim_way,
        .o_reply_kind, .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data,
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop well beyond clearing pass and all traffic
    initial begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

    // one request, held until accepted; start stays high until the caller idles
    task automatic send_request(logic f, logic [10:0] s, logic [3:0] w, logic h,
                                logic [47:0] a, logic [15:0] m);
        start <= 1;
        i_func <= f;
        i_set_index <= s;
        i_way_index <= w;
        i_was_hit <= h;
        i_phys_addr <= a;
        i_valid_mask <= m;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // one register write; valid stays high until the caller idles
    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic drain();
        start <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // random request: mostly strided accesses into a few sets
    task automatic random_request(int burst_set);
        logic [47:0] a;
        logic [10:0] s;
        s = ($urandom_range(0, 9) < 8) ? 11'(burst_set + $urandom_range(0, 3))
                                       : 11'($urandom);
        a = 48'({$urandom, $urandom});
        if ($urandom_range(0, 2) != 0)
            a = 48'({36'd0, 12'(s), 6'($urandom)} << $urandom_range(0, 12));
        if ($urandom_range(0, 30) == 0) a = 0;
        send_request(1'($urandom_range(0, 1)), s, 4'($urandom), 1'($urandom_range(0, 1)),
                     a, ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom));
    endtask

    initial begin
        int burst_set;
        start = 0;
        i_func = 0;
        i_set_index = 0;
        i_way_index = 0;
        i_was_hit = 0;
        i_phys_addr = 0;
        i_valid_mask = 0;
        i_cfg_valid = 0;
        i_cfg_index = alsb_pkg::CFG_REUSE;
        i_cfg_data = 0;
        i_rst_n = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extreme fields, hits, fills, aging, repeated and zero address
        send_request(0, 11'd0, 0, 0, 0, 16'hFFFF);
        send_request(0, 11'd2047, 0, 0, 0, 16'h0000);
        send_request(1, 11'd2047, 4'd15, 1, 48'hFFFF_FFFF_FFFF, 0);
        send_request(1, 11'd2047, 4'd15, 1, 48'hFFFF_FFFF_FFFF, 0);
        send_request(1, 11'd2047, 4'd0, 0, 48'd0, 0);
        send_request(1, 11'd2047, 4'd3, 0, 48'd64, 0);
        send_request(0, 11'd2047, 0, 0, 0, 16'hFFFF);
        for (int i = 0; i < 14; i++)
            send_request(1, 11'd5, 4'(i), 1, 48'h1000 + 48'(i * 64), 0);
        send_request(0, 11'd5, 0, 0, 0, 16'hFFFF);
        send_request(0, 11'd5, 0, 0, 0, 16'h7FFF);
        drain();

        // several configurations, extremes included
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    write_reg(alsb_pkg::CFG_REUSE, 0); write_reg(alsb_pkg::CFG_MODERATE, 0);
                    write_reg(alsb_pkg::CFG_STRIDE, 0); write_reg(alsb_pkg::CFG_RANDOM, 0);
                    write_reg(alsb_pkg::CFG_ODDS, 0); write_reg(alsb_pkg::CFG_SEED, 0);
                end
                1: begin
                    write_reg(alsb_pkg::CFG_REUSE, 63); write_reg(alsb_pkg::CFG_MODERATE, 32);
                    write_reg(alsb_pkg::CFG_STRIDE, 16'hFFFF);
                    write_reg(alsb_pkg::CFG_RANDOM, 255);
                    write_reg(alsb_pkg::CFG_ODDS, 15); write_reg(alsb_pkg::CFG_SEED, 16'hFFFF);
                end
                default: begin
                    write_reg(alsb_pkg::CFG_REUSE, 16'($urandom_range(0, 33)));
                    write_reg(alsb_pkg::CFG_MODERATE, 16'($urandom_range(0, 20)));
                    write_reg(alsb_pkg::CFG_STRIDE, 16'($urandom));
                    write_reg(alsb_pkg::CFG_RANDOM, 16'($urandom_range(0, 6)));
                    write_reg(alsb_pkg::CFG_ODDS, 16'($urandom_range(0, 4)));
                    write_reg(alsb_pkg::CFG_SEED, 16'($urandom));
                end
            endcase
            i_cfg_valid <= 0;
            burst_set = $urandom_range(0, 2040);
            for (int n = 0; n < 115; ) begin
                int len;
                len = $urandom_range(1, 20);
                for (int k = 0; k < len && n < 115; k++, n++) random_request(burst_set);
                start <= 0;
                if ($urandom_range(0, 2) != 0) repeat ($urandom_range(0, 8)) @(posedge i_clk);
            end
            // hold off until every result is back
            drain();
        end

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

[sim.f]
sv/alsb_pkg.sv
sv/alsb_cfg_regs.sv
sv/alsb_core.sv
sv/adaptive_lru_srrip_bip_replacement.sv
sv/alsb_checker.sv
tb/replacement_checker.sv
tb/tb_top.sv
